// ===== sv/gcsm_pkg.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// gcsm_pkg: shared definitions of the greedy caliper score matcher
// Sizes, register indexes, reset values and types used by the matcher.
// ---------------------------------------------------------------------------
package gcsm_pkg;

    // Table and list sizes.
    localparam int MAX_CONTROLS = 1024;
    localparam int IDX_W        = $clog2(MAX_CONTROLS);
    localparam int CNT_W        = IDX_W + 1;
    localparam int MAX_MATCHES  = 8;
    localparam int MM_IDX_W     = $clog2(MAX_MATCHES);
    localparam int MM_CNT_W     = MM_IDX_W + 1;

    // Field widths.
    localparam int SCORE_W = 16;
    localparam int CASE_W  = 16;
    localparam int MPC_W   = 4;
    localparam int ADDR_W  = 3;
    localparam int DATA_W  = 32;

    // Operation codes of an input word.
    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_MATCH = 1'b1;

    // Register reset values.
    localparam logic [SCORE_W-1:0] CALIPER_RESET = SCORE_W'(6554);
    localparam logic [MPC_W-1:0]   MPC_RESET     = MPC_W'(1);

    // Register indexes on the configuration port.
    typedef enum logic {
        REG_CALIPER = 1'b0,
        REG_MATCHES = 1'b1
    } t_reg_index;

    // Sequencer states.
    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_DRAIN,
        S_REPORT
    } t_state;

    // One entry of the nearest-candidate list.
    typedef struct packed {
        logic [IDX_W-1:0]   idx;
        logic [SCORE_W-1:0] diff;
    } t_best;

endpackage

// ===== sv/gcsm_ram.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// gcsm_ram: generic single-write, single-read RAM
// One write port and one read port, read data registered.
// ---------------------------------------------------------------------------
module gcsm_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write and registered read.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== sv/greedy_caliper_score_matcher.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// greedy_caliper_score_matcher: greedy nearest-neighbor caliper matching
// Keeps a table of control scores and assigns the nearest free controls
// within the caliper to each case.
// ---------------------------------------------------------------------------
// A load word (op 0) appends one control score; loads past the table size are
// dropped. A match word (op 1) makes one scan step per loaded control through
// the score and taken RAM read ports and a shared difference, caliper compare
// and sorted-insert unit, then gives one result word per cycle as the output
// takes them. The input is not ready while a match is under way. Results
// come out nearest first with ties to the lower load index; when too few
// free controls fall within the caliper, one no-match word is given and
// nothing is taken.
module greedy_caliper_score_matcher (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // Input words.
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic                          i_op,
    input  logic [gcsm_pkg::SCORE_W-1:0]  i_score,
    input  logic [gcsm_pkg::CASE_W-1:0]   i_case_number,
    // Result words.
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic [gcsm_pkg::IDX_W-1:0]    o_control_index,
    output logic [gcsm_pkg::CASE_W-1:0]   o_assigned_case,
    output logic                          o_matched,
    output logic                          o_last,
    // Configuration port.
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [gcsm_pkg::ADDR_W-1:0]   paddr,
    input  logic [gcsm_pkg::DATA_W-1:0]   pwdata,
    output logic [gcsm_pkg::DATA_W-1:0]   prdata,
    output logic                          pready
);

    import gcsm_pkg::*;

    t_state               r_state, n_state;
    logic [SCORE_W-1:0]   r_caliper;
    logic [MPC_W-1:0]     r_mpc;
    logic [CNT_W-1:0]     r_count;
    logic [SCORE_W-1:0]   r_score;
    logic [CASE_W-1:0]    r_case;
    logic [MM_CNT_W-1:0]  r_need;
    logic [CNT_W-1:0]     r_addr;
    logic                 r_p1_valid;
    logic [IDX_W-1:0]     r_p1_idx;
    logic                 r_p2_valid;
    logic [IDX_W-1:0]     r_p2_idx;
    logic [SCORE_W-1:0]   r_p2_diff;
    t_best                r_best [MAX_MATCHES];
    t_best                n_best [MAX_MATCHES];
    logic [MM_CNT_W-1:0]  r_filled, n_filled;
    logic [MM_CNT_W-1:0]  r_k;
    logic                 r_out_valid;
    logic [IDX_W-1:0]     r_out_idx;
    logic [CASE_W-1:0]    r_out_case;
    logic                 r_out_matched;
    logic                 r_out_last;

    logic                 cfg_we;
    logic                 in_fire;
    logic                 load_fire;
    logic                 match_fire;
    logic                 load_we;
    logic                 issue;
    logic                 emit;
    logic                 emit_match;
    logic                 emit_last;
    logic                 slot_free;
    logic [SCORE_W-1:0]   rd_score;
    logic                 rd_taken;
    logic [SCORE_W-1:0]   diff;
    logic                 eligible;
    logic [MAX_MATCHES-1:0] ins;
    logic                 accept;
    logic [MM_CNT_W-1:0]  need_m1;
    logic [MM_CNT_W-1:0]  need_sat;
    logic                 taken_we;
    logic [IDX_W-1:0]     taken_waddr;
    t_best                cur_best;
    t_best                new_best;

    // Configuration port: always ready, write on the access cycle.
    assign pready = 1'b1;
    assign cfg_we = psel && penable && pwrite && pready;

    always_comb begin
        case (t_reg_index'(paddr[2]))
            REG_CALIPER: prdata = DATA_W'(r_caliper);
            REG_MATCHES: prdata = DATA_W'(r_mpc);
            default:     prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_caliper <= CALIPER_RESET;
            r_mpc     <= MPC_RESET;
        end else if (cfg_we) begin
            case (t_reg_index'(paddr[2]))
                REG_CALIPER: r_caliper <= pwdata[SCORE_W-1:0];
                REG_MATCHES: r_mpc     <= pwdata[MPC_W-1:0];
                default: ;
            endcase
        end
    end

    // Matches per case, with zero raised to one and large values saturated.
    always_comb begin
        if (r_mpc == '0) begin
            need_sat = MM_CNT_W'(1);
        end else if (MM_CNT_W'(r_mpc) > MM_CNT_W'(MAX_MATCHES)) begin
            need_sat = MM_CNT_W'(MAX_MATCHES);
        end else begin
            need_sat = MM_CNT_W'(r_mpc);
        end
    end

    // Input handshake.
    assign o_in_ready = (r_state == S_IDLE);
    assign in_fire    = i_in_valid && o_in_ready;
    assign load_fire  = in_fire && (i_op == OP_LOAD);
    assign match_fire = in_fire && (i_op == OP_MATCH);
    assign load_we    = load_fire && (r_count < CNT_W'(MAX_CONTROLS));

    // Scan issue and output slot.
    assign issue     = (r_state == S_SCAN) && (r_addr != r_count);
    assign slot_free = !r_out_valid || i_out_ready;
    assign cur_best  = r_best[r_k[MM_IDX_W-1:0]];

    // Sequencer: next state and strobes.
    always_comb begin
        n_state    = r_state;
        emit       = 1'b0;
        emit_match = 1'b0;
        emit_last  = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (match_fire) begin
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                if (r_addr == r_count) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                if (!r_p1_valid && !r_p2_valid) begin
                    n_state = S_REPORT;
                end
            end
            S_REPORT: begin
                if (slot_free) begin
                    emit = 1'b1;
                    if (r_filled < r_need) begin
                        emit_last = 1'b1;
                        n_state   = S_IDLE;
                    end else begin
                        emit_match = 1'b1;
                        if (r_k + MM_CNT_W'(1) == r_need) begin
                            emit_last = 1'b1;
                            n_state   = S_IDLE;
                        end
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Control score and taken flag stores.
    assign taken_we    = load_we || emit_match;
    assign taken_waddr = emit_match ? cur_best.idx : r_count[IDX_W-1:0];

    gcsm_ram #(
        .WIDTH (SCORE_W),
        .DEPTH (MAX_CONTROLS)
    ) u_score_ram (
        .i_clk   (i_clk),
        .i_we    (load_we),
        .i_waddr (r_count[IDX_W-1:0]),
        .i_wdata (i_score),
        .i_raddr (r_addr[IDX_W-1:0]),
        .o_rdata (rd_score)
    );

    gcsm_ram #(
        .WIDTH (1),
        .DEPTH (MAX_CONTROLS)
    ) u_taken_ram (
        .i_clk   (i_clk),
        .i_we    (taken_we),
        .i_waddr (taken_waddr),
        .i_wdata (emit_match),
        .i_raddr (r_addr[IDX_W-1:0]),
        .o_rdata (rd_taken)
    );

    // Control count, case capture and scan address.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_addr  <= '0;
        end else begin
            if (load_we) begin
                r_count <= r_count + CNT_W'(1);
            end
            if (match_fire) begin
                r_addr <= '0;
            end else if (issue) begin
                r_addr <= r_addr + CNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (match_fire) begin
            r_score <= i_score;
            r_case  <= i_case_number;
            r_need  <= need_sat;
        end
    end

    // Difference and caliper check on the word read back.
    assign diff     = (rd_score > r_score) ? (rd_score - r_score) : (r_score - rd_score);
    assign eligible = !rd_taken && (diff <= r_caliper);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p1_valid <= 1'b0;
            r_p2_valid <= 1'b0;
        end else begin
            r_p1_valid <= issue;
            r_p2_valid <= r_p1_valid && eligible;
        end
    end

    always_ff @(posedge i_clk) begin
        r_p1_idx  <= r_addr[IDX_W-1:0];
        r_p2_idx  <= r_p1_idx;
        r_p2_diff <= diff;
    end

    // Sorted insert: a candidate goes ahead only of a strictly larger difference.
    assign new_best.idx  = r_p2_idx;
    assign new_best.diff = r_p2_diff;
    assign need_m1       = r_need - MM_CNT_W'(1);

    always_comb begin
        for (int k = 0; k < MAX_MATCHES; k++) begin
            ins[k] = (MM_CNT_W'(k) >= r_filled) || (r_best[k].diff > r_p2_diff);
        end
        accept = r_p2_valid && ((r_filled < r_need) || ins[need_m1[MM_IDX_W-1:0]]);
        n_best[0] = (accept && ins[0]) ? new_best : r_best[0];
        for (int k = 1; k < MAX_MATCHES; k++) begin
            if (accept && ins[k]) begin
                n_best[k] = ins[k-1] ? r_best[k-1] : new_best;
            end else begin
                n_best[k] = r_best[k];
            end
        end
        n_filled = (accept && (r_filled < r_need)) ? r_filled + MM_CNT_W'(1) : r_filled;
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < MAX_MATCHES; k++) begin
            r_best[k] <= n_best[k];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_filled <= '0;
            r_k      <= '0;
        end else if (match_fire) begin
            r_filled <= '0;
            r_k      <= '0;
        end else begin
            r_filled <= n_filled;
            if (emit) begin
                r_k <= r_k + MM_CNT_W'(1);
            end
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (emit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_out_idx     <= emit_match ? cur_best.idx : '0;
            r_out_case    <= r_case;
            r_out_matched <= emit_match;
            r_out_last    <= emit_last;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_control_index = r_out_idx;
    assign o_assigned_case = r_out_case;
    assign o_matched       = r_out_matched;
    assign o_last          = r_out_last;

endmodule
